// ----- hdl/cbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the counting Bloom filter
// Action codes, hash constants and the front-to-back job record.
// ----------------------------------------------------------------------------
package cbf_pkg;

	localparam logic [31:0] SEED_FIRST = 32'h9747b28c;
	localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_SUB   = 2'd1,
		ACT_CHECK = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	localparam logic [1:0] REG_NUM_COUNTERS = 2'd0;
	localparam logic [1:0] REG_NUM_HASHES   = 2'd1;

	// Job handed from the hashing front end to the counter back end.
	typedef struct packed {
		action_t     action;
		logic [31:0] a;
		logic [31:0] b;
	} job_t;

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_INIT,
		FR_BLOCK,
		FR_TAIL,
		FR_FIN1,
		FR_FIN2,
		FR_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_IDX,
		BK_MOD,
		BK_READ,
		BK_WAIT,
		BK_WRITE,
		BK_CLEAR,
		BK_OUT
	} back_state_t;

endpackage

// ----- hdl/counting_bloom_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_bloom_filter_top: counting Bloom filter with double hashing
// Keys are hashed twice with MurmurHash2; derived indexes address 16-bit
// wrapping counters that are added, subtracted, checked or cleared.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one key beat: action in tuser, key bytes and length in
//   tdata. m_axis returns one beat per key: the estimate (minimum counter for
//   check, zero otherwise).
//   Write num_counters (index 0) and num_hashes (index 1) on cfg_* while idle.
// Operation:
//   The front end hashes each key in two passes on one shared multiplier
//   and then offers the job to the queue. For each hash index the back end
//   runs an index multiply, a 32-step bit-serial modulo and a read-modify-write
//   through its read, wait and write states; a key holds it for all its
//   hash indexes. Clear sweeps all MAX_COUNTERS entries, one per cycle.
//   A two-entry job queue lets the front end hash the next key meanwhile.
// Reset:
//   Reset does not sweep the memory: after reset the block runs a clear
//   pass over all MAX_COUNTERS entries before the first key is taken.
// Stall:
//   When m_axis_tready is low the result holds and the back end waits;
//   the queue then fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module counting_bloom_filter_top #(
	parameter int MAX_COUNTERS  = 4096,
	parameter int MAX_HASHES    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // [63:0] key_bytes, [67:64] key_length, pad
	input  logic [1:0]  s_axis_tuser,   // [1:0] action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] estimate
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import cbf_pkg::*;

	localparam int AW = $clog2(MAX_COUNTERS);
	localparam int HW = $clog2(MAX_HASHES + 1);

	logic [12:0] num_counters_q;
	logic [4:0]  num_hashes_q;
	logic [AW:0] n_eff;
	logic [HW-1:0] k_eff;
	logic        init_q;   // clear pass after reset
	logic [AW-1:0] init_cnt_q;
	logic        fr_valid, fr_ready, bk_valid, bk_ready;
	job_t        fr_job, bk_job, q_job;
	logic        q_valid, q_ready;
	logic        in_valid, in_ready;
	logic        res_valid;
	logic [15:0] res_est;

	// clamp the registers as the block uses them
	always_comb begin
		if (num_counters_q == 13'd0) n_eff = (AW+1)'(1);
		else if ({19'd0, num_counters_q} > 32'(MAX_COUNTERS)) n_eff = (AW+1)'(MAX_COUNTERS);
		else n_eff = (AW+1)'(num_counters_q);
		if (num_hashes_q == 5'd0) k_eff = HW'(1);
		else if ({27'd0, num_hashes_q} > 32'(MAX_HASHES)) k_eff = HW'(MAX_HASHES);
		else k_eff = HW'(num_hashes_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_counters_q <= 13'd4096;
			num_hashes_q   <= 5'd4;
		end else if (cfg_we) begin
			if (cfg_index == REG_NUM_COUNTERS[0:0]) num_counters_q <= cfg_data;
			else                                     num_counters_q <= num_counters_q;
			if (cfg_index == REG_NUM_HASHES[0:0]) num_hashes_q <= cfg_data[4:0];
		end
	end

	// Post-reset clear: a hidden clear job through the back end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= 1'b1;
			init_cnt_q <= '0;
		end else if (init_q && q_ready) begin
			init_q <= 1'b0;
		end
	end

	// drop the busy flag once the hidden clear job has returned its beat
	logic init_busy_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_busy_q <= 1'b1;
		else if (res_valid) init_busy_q <= 1'b0;
	end

	assign in_valid      = s_axis_tvalid && !init_q && !init_busy_q;
	assign s_axis_tready = in_ready && !init_q && !init_busy_q;

	cbf_front u_front (
		.clk, .arst_n,
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (s_axis_tuser),
		.in_key    (s_axis_tdata[63:0]),
		.in_len    (s_axis_tdata[67:64]),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job       (fr_job)
	);

	always_comb begin
		q_job        = fr_job;
		q_valid      = fr_valid;
		fr_ready     = q_ready && !init_q;
		if (init_q) begin
			q_job.action = ACT_CLEAR;
			q_job.a      = 32'(init_cnt_q);
			q_job.b      = '0;
			q_valid      = 1'b1;
		end
	end

	cbf_queue u_queue (
		.clk, .arst_n,
		.wr_valid (q_valid),
		.wr_ready (q_ready),
		.wr_job   (q_job),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_job   (bk_job)
	);

	cbf_back #(.MAX_COUNTERS(MAX_COUNTERS), .MAX_HASHES(MAX_HASHES)) u_back (
		.clk, .arst_n,
		.job_valid    (bk_valid),
		.job_ready    (bk_ready),
		.job          (bk_job),
		.n_eff        (n_eff),
		.k_eff        (k_eff),
		.res_valid    (res_valid),
		.res_ready    (m_axis_tready || init_busy_q),
		.res_estimate (res_est)
	);

	// hide the result of the reset clear pass
	assign m_axis_tvalid = res_valid && !init_busy_q;
	assign m_axis_tdata  = res_est;

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result beat withdrawn");
	assert property (@(posedge clk) disable iff (!arst_n)
		init_busy_q |-> !s_axis_tready)
		else $error("key taken during reset clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

// ----- hdl/cbf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_front: key hashing front end
// Runs MurmurHash2 twice on a shared 32x32 multiplier, one multiply a cycle.
// ----------------------------------------------------------------------------
module cbf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_action,
	input  logic [63:0]       in_key,
	input  logic [3:0]        in_len,
	output logic              job_valid,
	input  logic              job_ready,
	output cbf_pkg::job_t     job
);
	import cbf_pkg::*;

	front_state_t state_q, state_d;
	logic [1:0]  action_q;
	logic [63:0] key_q;
	logic [3:0]  len_q;
	logic        pass_q;      // 0: first pass, 1: second pass
	logic        blk_q;       // which 4-byte block
	logic [1:0]  step_q;      // micro step inside a block
	logic [31:0] h_q, k_q, a_q;
	logic [31:0] mul_a, mul_p;
	logic [31:0] blk_word;
	logic [3:0]  rest;
	logic [31:0] tail_x;

	assign blk_word = blk_q ? key_q[63:32] : key_q[31:0];
	assign rest     = len_q - {1'b0, blk_q, 2'b00};

	always_comb begin
		tail_x = '0;
		case (rest[1:0])
			2'd3:    tail_x = {8'h00, blk_word[23:0]};
			2'd2:    tail_x = {16'h0000, blk_word[15:0]};
			2'd1:    tail_x = {24'h000000, blk_word[7:0]};
			default: tail_x = '0;
		endcase
	end

	assign mul_p = mul_a * MIX_MUL;

	always_comb begin
		mul_a = h_q;
		if (state_q == FR_BLOCK && step_q == 2'd0) mul_a = blk_word;
		else if (state_q == FR_BLOCK && step_q == 2'd1) mul_a = k_q ^ (k_q >> 24);
		else if (state_q == FR_TAIL) mul_a = h_q ^ tail_x;
		else if (state_q == FR_FIN1) mul_a = h_q ^ (h_q >> 13);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE:  if (in_valid) state_d = (in_action == ACT_CLEAR) ? FR_PUSH : FR_INIT;
			FR_INIT:  state_d = (len_q >= 4'd4) ? FR_BLOCK :
				(len_q != 4'd0 ? FR_TAIL : FR_FIN1);
			FR_BLOCK: if (step_q == 2'd2)
				state_d = (!blk_q && (rest >= 4'd8)) ? FR_BLOCK :
					((rest - 4'd4) != 4'd0 ? FR_TAIL : FR_FIN1);
			FR_TAIL:  state_d = FR_FIN1;
			FR_FIN1:  state_d = FR_FIN2;
			FR_FIN2:  state_d = pass_q ? FR_PUSH : FR_INIT;
			FR_PUSH:  if (job_ready) state_d = FR_IDLE;
			default:  state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == FR_IDLE);
		job_valid = (state_q == FR_PUSH);
		job.action = action_t'(action_q);
		job.a      = a_q;
		job.b      = h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				action_q <= in_action;
				key_q    <= in_key;
				len_q    <= (in_len > 4'd8) ? 4'd8 : in_len;
				pass_q   <= 1'b0;
			end
			FR_INIT: begin
				h_q    <= (pass_q ? a_q : SEED_FIRST) ^ {28'd0, len_q};
				blk_q  <= 1'b0;
				step_q <= 2'd0;
			end
			FR_BLOCK: begin
				case (step_q)
					2'd0:    begin k_q <= mul_p; step_q <= 2'd1; end
					2'd1:    begin k_q <= mul_p; step_q <= 2'd2; end
					default: begin
						h_q    <= mul_p ^ k_q;
						step_q <= 2'd0;
						blk_q  <= 1'b1;
					end
				endcase
				if (step_q == 2'd2 && !blk_q && rest < 4'd8) blk_q <= 1'b1;
				if (step_q == 2'd2 && !blk_q && rest >= 4'd8) blk_q <= 1'b1;
			end
			FR_TAIL: h_q <= mul_p;
			FR_FIN1: h_q <= mul_p;
			FR_FIN2: begin
				h_q <= h_q ^ (h_q >> 15);
				if (!pass_q) a_q <= h_q ^ (h_q >> 15);
				pass_q <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/cbf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_queue: two-entry job queue
// Decouples the hashing front end from the counter back end.
// ----------------------------------------------------------------------------
module cbf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  cbf_pkg::job_t wr_job,
	output logic          rd_valid,
	input  logic          rd_ready,
	output cbf_pkg::job_t rd_job
);
	import cbf_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job   = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count did not advance");

endmodule

// ----- hdl/cbf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_back: counter back end
// Derives indexes, reduces them modulo num_counters bit-serially and updates
// the counters by read-modify-write (check only reads; clear zeroes all).
// ----------------------------------------------------------------------------
module cbf_back #(
	parameter int MAX_COUNTERS = 4096,
	parameter int MAX_HASHES   = 16,
	localparam int AW = $clog2(MAX_COUNTERS),
	localparam int HW = $clog2(MAX_HASHES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  cbf_pkg::job_t job,
	input  logic [AW:0]   n_eff,
	input  logic [HW-1:0] k_eff,
	output logic          res_valid,
	input  logic          res_ready,
	output logic [15:0]   res_estimate
);
	import cbf_pkg::*;

	back_state_t state_q, state_d;
	logic [15:0] mem [MAX_COUNTERS];
	logic [15:0] rdata_s1;
	action_t     act_q;
	logic [31:0] a_q, b_q, idx_q, mul_p;
	logic [HW-1:0] i_q;
	logic [AW:0]   rem_q;
	logic [5:0]    bit_q;
	logic [AW+1:0] rem_sh;
	logic [AW-1:0] addr_q;
	logic [15:0]   best_q;

	assign mul_p  = {{(32-HW){1'b0}}, i_q} * b_q;
	assign rem_sh = {rem_q, idx_q[bit_q[4:0]]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:  if (job_valid) state_d = (job.action == ACT_CLEAR) ? BK_CLEAR : BK_IDX;
			BK_IDX:   state_d = BK_MOD;
			BK_MOD:   if (bit_q == 6'd0) state_d = BK_READ;
			BK_READ:  state_d = BK_WAIT;
			BK_WAIT:  state_d = BK_WRITE;
			BK_WRITE: state_d = ({1'b0, i_q} + (HW+1)'(1) >= {1'b0, k_eff}) ? BK_OUT : BK_IDX;
			BK_CLEAR: if (addr_q == AW'(MAX_COUNTERS - 1)) state_d = BK_OUT;
			BK_OUT:   if (res_ready) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_ready    = (state_q == BK_IDLE);
		res_valid    = (state_q == BK_OUT);
		res_estimate = (act_q == ACT_CHECK) ? best_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				act_q  <= job.action;
				a_q    <= job.a;
				b_q    <= job.b;
				i_q    <= '0;
				addr_q <= '0;
				best_q <= 16'hFFFF;
			end
			BK_IDX: begin
				idx_q <= a_q + mul_p;
				rem_q <= '0;
				bit_q <= 6'd31;
			end
			BK_MOD: begin
				// restoring step: one quotient bit a cycle
				if (rem_sh >= {1'b0, n_eff}) rem_q <= (AW+1)'(rem_sh - {1'b0, n_eff});
				else                         rem_q <= rem_sh[AW:0];
				if (bit_q != 6'd0) bit_q <= bit_q - 6'd1;
			end
			BK_READ:  addr_q <= rem_q[AW-1:0];
			BK_WRITE: begin
				if (act_q == ACT_CHECK && rdata_s1 < best_q) best_q <= rdata_s1;
				i_q <= i_q + HW'(1);
			end
			BK_CLEAR: addr_q <= addr_q + AW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[addr_q];
		if (state_q == BK_WRITE && act_q == ACT_ADD)  mem[addr_q] <= rdata_s1 + 16'd1;
		if (state_q == BK_WRITE && act_q == ACT_SUB)  mem[addr_q] <= rdata_s1 - 16'd1;
		if (state_q == BK_CLEAR) mem[addr_q] <= 16'd0;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_OUT && !res_ready) |=> (state_q == BK_OUT))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ) |-> (rem_q < n_eff))
		else $error("index not reduced");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_WRITE) |-> ({1'b0, i_q} < {1'b0, k_eff}))
		else $error("hash count overrun");

endmodule

// ----- bench/tb_counting_bloom_filter_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counting_bloom_filter_top: self-checking bench of the counting Bloom filter
// Drives key beats with random gaps and result stalls, predicts every estimate
// with its own double MurmurHash2 and counter store, and checks each result
// beat in order. Sweeps several num_counters / num_hashes settings, extremes
// and out-of-range values included, between idle phases.
// ----------------------------------------------------------------------------
module tb_counting_bloom_filter_top;
	import cbf_pkg::*;

	localparam int STORE_DEPTH = 4096;
	localparam int HASH_LIMIT  = 16;
	localparam int KEY_LIMIT   = 8;
	localparam int DRAIN_WAIT  = 700;  // one 16-hash key plus margin
	localparam int RANDOM_ITEMS = 1330;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;   // [63:0] key_bytes, [67:64] key_length, pad
	logic [1:0]  s_axis_tuser;   // [1:0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] estimate
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_data;

	counting_bloom_filter_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Shadow state of the filter
	logic [15:0] shadow_counters [STORE_DEPTH];
	logic [12:0] shadow_num_counters;
	logic [4:0]  shadow_num_hashes;

	logic [15:0] pending_estimates [$];
	int          error_count;
	int          keys_sent, checks_seen, nonzero_checks, clears_sent;

	typedef struct {
		action_t     action;
		logic [63:0] key;
		logic [3:0]  len;
		bit          typed;
		logic [15:0] estimate;
	} key_row_t;

	key_row_t directed_rows [$];
	logic [63:0] key_pool [8];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// 32-bit MurmurHash2 over the first len bytes of key
	function automatic logic [31:0] murmur_hash(input logic [63:0] key, input int unsigned len,
			input logic [31:0] seed);
		logic [31:0] h;
		logic [31:0] k;
		int unsigned pos;
		int unsigned rest;
		h = seed ^ len;
		pos = 0;
		rest = len;
		while (rest >= 4) begin
			k = key[pos*8 +: 32];
			k = k * MIX_MUL;
			k = k ^ (k >> 24);
			k = k * MIX_MUL;
			h = h * MIX_MUL;
			h = h ^ k;
			pos += 4;
			rest -= 4;
		end
		if (rest == 3) h = h ^ ({24'd0, key[(pos+2)*8 +: 8]} << 16);
		if (rest >= 2) h = h ^ ({24'd0, key[(pos+1)*8 +: 8]} << 8);
		if (rest >= 1) begin
			h = h ^ {24'd0, key[pos*8 +: 8]};
			h = h * MIX_MUL;
		end
		h = h ^ (h >> 13);
		h = h * MIX_MUL;
		h = h ^ (h >> 15);
		return h;
	endfunction

	// Apply one key to the shadow store and return the estimate it yields
	function automatic logic [15:0] apply_key(input action_t action, input logic [63:0] key,
			input logic [3:0] len);
		int unsigned eff_len;
		int unsigned modulus;
		int unsigned hashes;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] mix;
		int unsigned slot;
		logic [15:0] lowest;
		if (action == ACT_CLEAR) begin
			foreach (shadow_counters[i]) shadow_counters[i] = '0;
			return '0;
		end
		eff_len = (len > KEY_LIMIT) ? KEY_LIMIT : len;
		modulus = (shadow_num_counters == 0) ? 1 : shadow_num_counters;
		if (modulus > STORE_DEPTH) modulus = STORE_DEPTH;
		hashes = (shadow_num_hashes == 0) ? 1 : shadow_num_hashes;
		if (hashes > HASH_LIMIT) hashes = HASH_LIMIT;
		a = murmur_hash(key, eff_len, SEED_FIRST);
		b = murmur_hash(key, eff_len, a);
		lowest = 16'hFFFF;
		for (int unsigned i = 0; i < hashes; i++) begin
			mix = a + i * b;
			slot = mix % modulus;
			case (action)
				ACT_ADD: shadow_counters[slot] = shadow_counters[slot] + 16'd1;
				ACT_SUB: shadow_counters[slot] = shadow_counters[slot] - 16'd1;
				default: if (shadow_counters[slot] < lowest) lowest = shadow_counters[slot];
			endcase
		end
		return (action == ACT_CHECK) ? lowest : 16'd0;
	endfunction

	// Write both registers while the block is idle; hold cfg_we across the pair
	task automatic write_config(input logic [12:0] counters, input logic [4:0] hashes);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_COUNTERS[0:0];
		cfg_data  <= counters;
		@(posedge clk);
		shadow_num_counters = counters;
		cfg_index <= REG_NUM_HASHES[0:0];
		cfg_data  <= {8'd0, hashes};
		@(posedge clk);
		shadow_num_hashes = hashes;
		cfg_we <= 1'b0;
	endtask

	// Present one key beat, hold it until taken, then queue its estimate
	task automatic send_key(input action_t action, input logic [63:0] key, input logic [3:0] len,
			input bit typed, input logic [15:0] typed_estimate);
		logic [15:0] predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, len, key};
		s_axis_tuser  <= action;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		predicted = apply_key(action, key, len);
		pending_estimates.push_back(typed ? typed_estimate : predicted);
		keys_sent++;
		if (action == ACT_CLEAR) clears_sent++;
	endtask

	// Random idle after a beat: mostly back-to-back, sometimes short, rarely long
	task automatic sender_gap();
		int unsigned roll;
		int unsigned gap;
		roll = $urandom_range(99);
		if (roll < 55) gap = 0;
		else if (roll < 92) gap = $urandom_range(1, 4);
		else gap = $urandom_range(10, 60);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every estimate has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_estimates.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic add_row(input action_t action, input logic [63:0] key, input logic [3:0] len,
			input bit typed, input logic [15:0] estimate);
		key_row_t row;
		row.action   = action;
		row.key      = key;
		row.len      = len;
		row.typed    = typed;
		row.estimate = estimate;
		directed_rows.push_back(row);
	endtask

	// Result side: random stalls, with long runs of ready
	int unsigned ready_hold;
	always @(posedge clk or negedge arst_n) begin
		int unsigned roll;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				m_axis_tready <= 1'b1;
				ready_hold    <= $urandom_range(1, 50);
			end else if (roll < 90) begin
				m_axis_tready <= 1'b0;
				ready_hold    <= $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b0;
				ready_hold    <= $urandom_range(10, 80);
			end
		end
	end

	// Compare each result beat with the oldest pending estimate
	always @(posedge clk) begin
		logic [15:0] wanted;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_estimates.size() == 0) begin
				$display("%0t: unexpected result beat, estimate 0x%04h", $time, m_axis_tdata);
				error_count++;
			end else begin
				wanted = pending_estimates.pop_front();
				if (m_axis_tdata !== wanted) begin
					$display("%0t: estimate mismatch, expected 0x%04h, got 0x%04h",
						$time, wanted, m_axis_tdata);
					error_count++;
				end
				if (wanted != 0) nonzero_checks++;
			end
		end
	end

	// Safety net against a hung handshake
	initial begin
		#100_000_000;
		$display("timeout with %0d estimates outstanding", pending_estimates.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [12:0] phase_counters [10];
		logic [4:0]  phase_hashes [10];
		int unsigned per_phase;
		int unsigned roll;
		action_t     action;
		logic [63:0] key;
		logic [3:0]  len;

		// Every input known from time zero
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		error_count   = 0;
		keys_sent     = 0;
		checks_seen   = 0;
		nonzero_checks = 0;
		clears_sent   = 0;
		foreach (shadow_counters[i]) shadow_counters[i] = '0;
		shadow_num_counters = 13'd4096;
		shadow_num_hashes   = 5'd4;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: fresh store, extremes of length and key,
		// long keys, counter wrap both ways, and clear
		add_row(ACT_CHECK, 64'd0, 4'd0, 1'b1, 16'd0);
		add_row(ACT_CHECK, '1, 4'd8, 1'b1, 16'd0);
		add_row(ACT_ADD, 64'd0, 4'd0, 1'b1, 16'd0);
		add_row(ACT_ADD, '1, 4'd8, 1'b1, 16'd0);
		add_row(ACT_CHECK, 64'd0, 4'd0, 1'b0, 16'd0);
		add_row(ACT_CHECK, '1, 4'd8, 1'b0, 16'd0);
		add_row(ACT_CHECK, '1, 4'd15, 1'b0, 16'd0);          // long key aliases length 8
		add_row(ACT_CHECK, 64'h0123_4567_89ab_cdef, 4'd9, 1'b0, 16'd0);
		add_row(ACT_SUB, 64'h1122_3344_5566_7788, 4'd5, 1'b1, 16'd0);
		add_row(ACT_CHECK, 64'h1122_3344_5566_7788, 4'd5, 1'b0, 16'd0); // wrapped below zero
		add_row(ACT_ADD, 64'h1122_3344_5566_7788, 4'd5, 1'b1, 16'd0);
		add_row(ACT_ADD, 64'hFFFF_FF11_2233_4455, 4'd5, 1'b1, 16'd0); // junk above length
		add_row(ACT_CHECK, 64'h1122_3344_5566_7788, 4'd5, 1'b0, 16'd0);
		add_row(ACT_SUB, 64'd0, 4'd0, 1'b1, 16'd0);
		add_row(ACT_CHECK, 64'd0, 4'd0, 1'b0, 16'd0);
		add_row(ACT_ADD, 64'h0000_0000_00A5_5AC3, 4'd1, 1'b1, 16'd0);
		add_row(ACT_ADD, 64'h0000_0000_00A5_5AC3, 4'd2, 1'b1, 16'd0);
		add_row(ACT_ADD, 64'h0000_0000_00A5_5AC3, 4'd3, 1'b1, 16'd0);
		add_row(ACT_ADD, 64'h0000_0000_00A5_5AC3, 4'd4, 1'b1, 16'd0);
		add_row(ACT_CHECK, 64'h0000_0000_00A5_5AC3, 4'd3, 1'b0, 16'd0);
		add_row(ACT_CLEAR, '1, 4'd8, 1'b1, 16'd0);
		add_row(ACT_CHECK, '1, 4'd8, 1'b1, 16'd0);
		add_row(ACT_CHECK, 64'h1122_3344_5566_7788, 4'd5, 1'b1, 16'd0);
		foreach (directed_rows[r]) begin
			send_key(directed_rows[r].action, directed_rows[r].key, directed_rows[r].len,
				directed_rows[r].typed, directed_rows[r].estimate);
			if (directed_rows[r].action == ACT_CHECK) checks_seen++;
			sender_gap();
		end
		drain();

		// Settings per phase: extremes, zero and out-of-range values, tiny tables
		phase_counters = '{13'd1, 13'd0, 13'd8191, 13'd4096, 13'd7, 13'd100,
			13'd4095, 13'd2, 13'd0, 13'd4096};
		phase_hashes   = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd3, 5'd2, 5'd17, 5'd5, 5'd16, 5'd4};
		for (int p = 0; p < 12; p++) begin
			if (p < 10) write_config(phase_counters[p], phase_hashes[p]);
			else write_config(13'($urandom_range(1, 8191)), 5'($urandom_range(0, 31)));
			foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
			per_phase = RANDOM_ITEMS / 12;
			for (int n = 0; n < per_phase; n++) begin
				// Mid-phase hold-off until the pipeline is empty
				if (n == per_phase / 2 && p % 3 == 0) drain();
				roll = $urandom_range(99);
				if (roll < 40) action = ACT_ADD;
				else if (roll < 58) action = ACT_SUB;
				else if (roll < 98) action = ACT_CHECK;
				else action = ACT_CLEAR;
				// Reuse a few keys so checks hit counters that were touched
				key = ($urandom_range(99) < 75) ? key_pool[3'($urandom_range(7))]
					: {$urandom, $urandom};
				len = ($urandom_range(99) < 85) ? 4'($urandom_range(0, 8))
					: 4'($urandom_range(9, 15));
				send_key(action, key, len, 1'b0, 16'd0);
				if (action == ACT_CHECK) checks_seen++;
				sender_gap();
			end
			drain();
		end

		$display("sent %0d keys (%0d checks, %0d clears) over 13 settings;", keys_sent,
			checks_seen, clears_sent);
		$display("%0d results carried a nonzero estimate, %0d errors", nonzero_checks,
			error_count);
		if (error_count == 0 && pending_estimates.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/cbf_pkg.sv
hdl/cbf_front.sv
hdl/cbf_queue.sv
hdl/cbf_back.sv
hdl/counting_bloom_filter_top.sv
bench/tb_counting_bloom_filter_top.sv
